>>> sv/tcp_byte_stream_reassembler_top_macros.svh
// ----------------------------------------------------------------------------
// tcp_byte_stream_reassembler_top_macros
// assertion macros used by the reassembler datapath
// ----------------------------------------------------------------------------
`ifndef TCP_BYTE_STREAM_REASSEMBLER_TOP_MACROS_SVH
`define TCP_BYTE_STREAM_REASSEMBLER_TOP_MACROS_SVH

// same-cycle implication
`define TCPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tcpr_pkg.sv
// ----------------------------------------------------------------------------
// tcpr_pkg
// shared types and constants of the byte stream reassembler
// ----------------------------------------------------------------------------
`default_nettype none

package tcpr_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int IDX_W     = 64;
  localparam int DATA_W    = 8;
  localparam int SPACE_W   = 7;
  localparam int PEND_W    = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_CHECK,
    ST_READ,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic capture;
    logic limit;
    logic check;
    logic rd;
    logic emit;
    logic empty;
  } cmd_t;

  typedef struct packed {
    logic seg_open;
    logic seg_end;
    logic slot_rdy;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> sv/tcp_byte_stream_reassembler_top.sv
// ----------------------------------------------------------------------------
// tcp_byte_stream_reassembler_top
// reassembles an in-order byte stream from tagged segment bytes
// ----------------------------------------------------------------------------
// usage
//   input channel seg_valid / seg_stall carries one byte per transaction with
//   its absolute stream index; segment_end closes a segment and starts a drain
//   output channel res_valid / res_stall returns the drained bytes in order,
//   or one empty result when nothing is contiguous; last_of_run marks the end
// sequence
//   a transaction inside a segment is captured, then window compared and
//   ring written; the first of a segment adds the window limit in between
//   a drain does a ring read, then a result load, per delivered byte,
//   or one empty result load; one transaction is handled at a time
//   first result follows the segment_end transaction through window check,
//   ring read and result load, after a limit add if it also opens its segment
// reset
//   rst clears all ready bits, pointers and counts at once; no clearing pass
// stall
//   a stalled result holds in the output register; the drain pauses and the
//   next transaction is taken once the drain of the current one is done
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_byte_stream_reassembler_top #(
  parameter int DEPTH = tcpr_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         seg_valid,
  output logic                              seg_stall,
  input  wire logic                         has_byte,
  input  wire logic [tcpr_pkg::IDX_W-1:0]   stream_index,
  input  wire logic [tcpr_pkg::DATA_W-1:0]  data_byte,
  input  wire logic                         segment_end,
  input  wire logic                         final_segment,
  input  wire logic [tcpr_pkg::SPACE_W-1:0] window_space,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic                              byte_valid,
  output logic [tcpr_pkg::DATA_W-1:0]       out_byte,
  output logic                              last_of_run,
  output logic                              stream_closed,
  output logic [tcpr_pkg::PEND_W-1:0]       pending_count
);

  import tcpr_pkg::*;

  cmd_t    cmd;
  status_t status;

  tcpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .status    (status),
    .cmd       (cmd)
  );

  tcpr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .has_byte      (has_byte),
    .stream_index  (stream_index),
    .data_byte     (data_byte),
    .segment_end   (segment_end),
    .final_segment (final_segment),
    .window_space  (window_space),
    .cmd           (cmd),
    .status        (status),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .byte_valid    (byte_valid),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .stream_closed (stream_closed),
    .pending_count (pending_count)
  );

endmodule

`default_nettype wire

>>> sv/tcpr_ram.sv
// ----------------------------------------------------------------------------
// tcpr_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module tcpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/tcpr_ctrl.sv
// ----------------------------------------------------------------------------
// tcpr_ctrl
// sequencer for insert, drain and result issue
// ----------------------------------------------------------------------------
`default_nettype none

module tcpr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              seg_valid,
  output logic                   seg_stall,
  input  wire tcpr_pkg::status_t status,
  output tcpr_pkg::cmd_t         cmd
);

  import tcpr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (seg_valid) begin
          state_next = status.seg_open ? ST_CHECK : ST_LIMIT;
        end
      end
      ST_LIMIT: state_next = ST_CHECK;
      ST_CHECK: state_next = status.seg_end ? ST_READ : ST_IDLE;
      ST_READ:  state_next = status.slot_rdy ? ST_EMIT : ST_EMPTY;
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.slot_rdy ? ST_READ : ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    seg_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        seg_stall   = 1'b0;
        cmd.capture = seg_valid;
      end
      ST_LIMIT: cmd.limit = 1'b1;
      ST_CHECK: cmd.check = 1'b1;
      ST_READ:  cmd.rd    = status.slot_rdy;
      ST_EMIT:  cmd.emit  = status.out_free;
      ST_EMPTY: cmd.empty = status.out_free;
      default:  cmd       = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tcpr_dpath.sv
// ----------------------------------------------------------------------------
// tcpr_dpath
// window check, ring store, ready bits, stream pointers and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "tcp_byte_stream_reassembler_top_macros.svh"

module tcpr_dpath #(
  parameter int DEPTH = tcpr_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         has_byte,
  input  wire logic [tcpr_pkg::IDX_W-1:0]   stream_index,
  input  wire logic [tcpr_pkg::DATA_W-1:0]  data_byte,
  input  wire logic                         segment_end,
  input  wire logic                         final_segment,
  input  wire logic [tcpr_pkg::SPACE_W-1:0] window_space,
  input  wire tcpr_pkg::cmd_t               cmd,
  output tcpr_pkg::status_t                 status,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output logic                              byte_valid,
  output logic [tcpr_pkg::DATA_W-1:0]       out_byte,
  output logic                              last_of_run,
  output logic                              stream_closed,
  output logic [tcpr_pkg::PEND_W-1:0]       pending_count
);

  import tcpr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]        DEPTH_W   = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0]      LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [SPACE_W-1:0] DEPTH_S   = SPACE_W'(DEPTH);

  // captured transaction
  logic               in_has;
  logic [IDX_W-1:0]   in_idx;
  logic [DATA_W-1:0]  in_data;
  logic               in_end;
  logic               in_fin;
  logic [SPACE_W-1:0] in_space;

  // stream state
  logic [DEPTH-1:0] ready;
  logic [IDX_W-1:0] next_expected;
  logic [AW-1:0]    read_slot;
  logic [CW-1:0]    count;
  logic [IDX_W-1:0] final_index;
  logic             final_known;
  logic [IDX_W-1:0] window_limit;
  logic             seg_open;

  logic [SPACE_W-1:0] space_c;
  logic [IDX_W:0]     limit_sum;
  logic [AW-1:0]      offset;
  logic [AW:0]        pos_sum;
  logic [AW:0]        pos_wide;
  logic [AW-1:0]      pos;
  logic               in_win;
  logic               hit;
  logic [DATA_W-1:0]  rdata;
  logic               out_free;
  logic               closed_now;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_has   <= has_byte;
      in_idx   <= stream_index;
      in_data  <= data_byte;
      in_end   <= segment_end;
      in_fin   <= final_segment;
      in_space <= window_space;
    end
  end

  // clamped, saturating window limit
  assign space_c   = (in_space > DEPTH_S) ? DEPTH_S : in_space;
  assign limit_sum = {1'b0, next_expected} + (IDX_W + 1)'(space_c);

  // ring slot from the distance to the next expected byte
  assign offset   = in_idx[AW-1:0] - next_expected[AW-1:0];
  assign pos_sum  = {1'b0, read_slot} + {1'b0, offset};
  assign pos_wide = (pos_sum >= DEPTH_W) ? (pos_sum - DEPTH_W) : pos_sum;
  assign pos      = pos_wide[AW-1:0];

  assign in_win = in_has && (in_idx >= next_expected) && (in_idx < window_limit);
  assign hit    = cmd.check && in_win && !ready[pos];

  assign out_free   = !res_valid || !res_stall;
  assign closed_now = final_known && (next_expected == final_index);

  assign status.seg_open = seg_open;
  assign status.seg_end  = in_end;
  assign status.slot_rdy = ready[read_slot];
  assign status.out_free = out_free;

  tcpr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (hit),
    .waddr (pos),
    .wdata (in_data),
    .re    (cmd.rd),
    .raddr (read_slot),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.limit) begin
      window_limit <= limit_sum[IDX_W] ? '1 : limit_sum[IDX_W-1:0];
    end
    if (cmd.check && in_end && in_fin) begin
      final_index <= in_idx + IDX_W'(in_has);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready         <= '0;
      next_expected <= '0;
      read_slot     <= '0;
      count         <= '0;
      final_known   <= 1'b0;
      seg_open      <= 1'b0;
    end else begin
      if (cmd.limit) begin
        seg_open <= 1'b1;
      end
      if (cmd.check) begin
        if (in_end) begin
          seg_open <= 1'b0;
        end
        if (in_end && in_fin) begin
          final_known <= 1'b1;
        end
      end
      if (hit) begin
        ready[pos] <= 1'b1;
        count      <= count + 1'b1;
      end
      if (cmd.rd) begin
        ready[read_slot] <= 1'b0;
        count            <= count - 1'b1;
        next_expected    <= next_expected + 1'b1;
        read_slot        <= (read_slot == LAST_SLOT) ? '0 : read_slot + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit || cmd.empty) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      byte_valid    <= 1'b1;
      out_byte      <= rdata;
      last_of_run   <= !ready[read_slot];
      stream_closed <= closed_now;
      pending_count <= PEND_W'(count);
    end else if (cmd.empty) begin
      byte_valid    <= 1'b0;
      out_byte      <= '0;
      last_of_run   <= 1'b1;
      stream_closed <= closed_now;
      pending_count <= PEND_W'(count);
    end
  end

  `TCPR_ASSERT_NOW(a_count_match, 1'b1, count == CW'($countones(ready)),
    "stored count differs from ready bits")
  `TCPR_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH),
    "stored count beyond ring depth")
  `TCPR_ASSERT_NEXT(a_drain_clears, cmd.rd, !ready[$past(read_slot)],
    "drained slot still ready")
  `TCPR_ASSERT_NOW(a_empty_last, res_valid && !byte_valid, last_of_run,
    "empty result not marked last")

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the byte stream reassembler
// ----------------------------------------------------------------------------
// a short table of directed segments is sent first, then random segments that
// are built around the stream position the bench tracks itself; every drained
// result is checked field by field against an in-bench model of the ring or a
// directed row's own result, with random idling on both channels, one long
// output hold-off and one pause of the sender until all due results are back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = tcpr_pkg::DEPTH_DEF;
  localparam int IW    = tcpr_pkg::IDX_W;
  localparam int DW    = tcpr_pkg::DATA_W;
  localparam int SW    = tcpr_pkg::SPACE_W;
  localparam int PW    = tcpr_pkg::PEND_W;

  typedef struct packed {
    logic          has;
    logic [IW-1:0] idx;
    logic [DW-1:0] data;
    logic          last_item;
    logic          fin;
    logic [SW-1:0] space;
  } seg_item_t;

  typedef struct packed {
    logic          bv;
    logic [DW-1:0] b;
    logic          last;
    logic          closed;
    logic [PW-1:0] pend;
  } drain_res_t;

  typedef struct packed {
    seg_item_t  it;
    logic       typed;
    drain_res_t want;
  } row_t;

  logic          clk;
  logic          rst;
  logic          seg_valid;
  logic          seg_stall;
  logic          has_byte;
  logic [IW-1:0] stream_index;
  logic [DW-1:0] data_byte;
  logic          segment_end;
  logic          final_segment;
  logic [SW-1:0] window_space;
  logic          res_valid;
  logic          res_stall;
  logic          byte_valid;
  logic [DW-1:0] out_byte;
  logic          last_of_run;
  logic          stream_closed;
  logic [PW-1:0] pending_count;

  // stream model
  logic [DW-1:0] ring_data [DEPTH];
  logic          ring_full [DEPTH];
  logic [IW-1:0] exp_next;
  int            rd_ptr;
  int            held_cnt;
  logic [IW-1:0] close_idx;
  logic          close_known;
  logic [IW-1:0] win_lim;
  logic          mid_seg;

  drain_res_t drained_due[$];
  seg_item_t  seg_q[$];
  row_t       dir_rows[$];
  int         errors   = 0;
  logic       hold_req = 1'b0;
  logic       tx_calm  = 1'b0;
  logic       rx_calm  = 1'b0;

  tcp_byte_stream_reassembler_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .seg_valid    (seg_valid),
    .seg_stall    (seg_stall),
    .has_byte     (has_byte),
    .stream_index (stream_index),
    .data_byte    (data_byte),
    .segment_end  (segment_end),
    .final_segment(final_segment),
    .window_space (window_space),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .byte_valid   (byte_valid),
    .out_byte     (out_byte),
    .last_of_run  (last_of_run),
    .stream_closed(stream_closed),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic seg_item_t mk_item(input logic has, input logic [IW-1:0] idx,
                                        input logic [DW-1:0] data, input logic last_item,
                                        input logic fin, input logic [SW-1:0] sp);
    seg_item_t it;
    it.has       = has;
    it.idx       = idx;
    it.data      = data;
    it.last_item = last_item;
    it.fin       = fin;
    it.space     = sp;
    return it;
  endfunction

  function automatic drain_res_t mk_res(input logic bv, input logic [DW-1:0] b,
                                        input logic last, input logic closed,
                                        input logic [PW-1:0] pend);
    drain_res_t r;
    r.bv     = bv;
    r.b      = b;
    r.last   = last;
    r.closed = closed;
    r.pend   = pend;
    return r;
  endfunction

  task automatic add_row(input seg_item_t it, input logic typed, input drain_res_t want);
    row_t r;
    r.it    = it;
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  // updates the stream state for one accepted transaction and queues its results
  task automatic reassemble_item(input seg_item_t it);
    logic [IW:0] sum;
    int          span;
    int          pos;
    int          n;
    drain_res_t  r;
    if (!mid_seg) begin
      span    = (it.space > DEPTH) ? DEPTH : int'(it.space);
      sum     = {1'b0, exp_next} + (IW + 1)'(span);
      win_lim = sum[IW] ? '1 : sum[IW-1:0];
      mid_seg = 1'b1;
    end
    if (it.has && it.idx >= exp_next && it.idx < win_lim) begin
      pos = int'(it.idx % DEPTH);
      if (!ring_full[pos]) begin
        ring_data[pos] = it.data;
        ring_full[pos] = 1'b1;
        if (held_cnt < DEPTH) held_cnt++;
      end
    end
    if (!it.last_item) return;
    mid_seg = 1'b0;
    if (it.fin) begin
      close_idx   = it.idx + IW'(it.has);
      close_known = 1'b1;
    end
    n = 0;
    while (n < DEPTH && ring_full[rd_ptr]) begin
      ring_full[rd_ptr] = 1'b0;
      if (held_cnt > 0) held_cnt--;
      exp_next++;
      r.bv     = 1'b1;
      r.b      = ring_data[rd_ptr];
      r.last   = (n + 1 >= DEPTH) || !ring_full[(rd_ptr + 1) % DEPTH];
      r.closed = close_known && exp_next == close_idx;
      r.pend   = PW'(held_cnt);
      drained_due.push_back(r);
      rd_ptr = (rd_ptr + 1) % DEPTH;
      n++;
    end
    if (n == 0) begin
      r        = '0;
      r.last   = 1'b1;
      r.closed = close_known && exp_next == close_idx;
      r.pend   = PW'(held_cnt);
      drained_due.push_back(r);
    end
  endtask

  task automatic send_item(input seg_item_t it, input logic typed, input drain_res_t want);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      seg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_valid     <= 1'b1;
    has_byte      <= it.has;
    stream_index  <= it.idx;
    data_byte     <= it.data;
    segment_end   <= it.last_item;
    final_segment <= it.fin;
    window_space  <= it.space;
    @(posedge clk);
    while (seg_stall) @(posedge clk);
    reassemble_item(it);
    if (typed) drained_due[drained_due.size() - 1] = want;
  endtask

  // contiguous run of bytes, optionally sent highest index first
  task automatic add_run(input logic [IW-1:0] base, input int len, input logic [SW-1:0] sp,
                         input logic fin, input logic rev);
    logic [IW-1:0] ix;
    for (int i = 0; i < len; i++) begin
      ix = rev ? base + IW'(len - 1 - i) : base + IW'(i);
      seg_q.push_back(mk_item(1'b1, ix, DW'($urandom), i == len - 1,
                              (i == len - 1) ? fin : 1'($urandom),
                              (i == 0) ? sp : SW'($urandom_range(0, 64))));
    end
  endtask

  initial begin
    int            kind;
    int            len;
    int            sent;
    int            wait_cnt;
    logic [SW-1:0] sp;
    logic          fill_due;
    logic          hold_done;
    logic          pause_done;
    seg_valid     <= 1'b0;
    has_byte      <= 1'b0;
    stream_index  <= '0;
    data_byte     <= '0;
    segment_end   <= 1'b0;
    final_segment <= 1'b0;
    window_space  <= '0;
    rst           <= 1'b1;
    foreach (ring_full[i]) begin
      ring_full[i] = 1'b0;
      ring_data[i] = '0;
    end
    exp_next    = '0;
    rd_ptr      = 0;
    held_cnt    = 0;
    close_idx   = '0;
    close_known = 1'b0;
    win_lim     = '0;
    mid_seg     = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    add_row(mk_item(1'b0, 64'd0, 8'h00, 1'b1, 1'b0, 7'd0), 1'b1,
            mk_res(1'b0, 8'h00, 1'b1, 1'b0, 7'd0));
    add_row(mk_item(1'b1, 64'd0, 8'h5a, 1'b1, 1'b0, 7'd0), 1'b1,
            mk_res(1'b0, 8'h00, 1'b1, 1'b0, 7'd0));
    add_row(mk_item(1'b1, 64'd5, 8'hff, 1'b0, 1'b0, 7'd64), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd63, 8'h00, 1'b0, 1'b1, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd64, 8'h77, 1'b0, 1'b0, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b1, 64'hffff_ffff_ffff_ffff, 8'haa, 1'b1, 1'b0, 7'd0), 1'b1,
            mk_res(1'b0, 8'h00, 1'b1, 1'b0, 7'd2));
    add_row(mk_item(1'b1, 64'd0, 8'h11, 1'b0, 1'b0, 7'd127), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd1, 8'h22, 1'b0, 1'b0, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd2, 8'h33, 1'b0, 1'b1, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd3, 8'h44, 1'b0, 1'b0, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd4, 8'h80, 1'b0, 1'b0, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd5, 8'h01, 1'b1, 1'b0, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd2, 8'h99, 1'b1, 1'b0, 7'd10), 1'b0, '0);
    add_row(mk_item(1'b0, 64'd6, 8'h00, 1'b1, 1'b1, 7'd0), 1'b1,
            mk_res(1'b0, 8'h00, 1'b1, 1'b1, 7'd1));
    add_row(mk_item(1'b1, 64'hffff_ffff_ffff_ffff, 8'h3c, 1'b1, 1'b1, 7'd64), 1'b1,
            mk_res(1'b0, 8'h00, 1'b1, 1'b0, 7'd1));
    add_row(mk_item(1'b1, 64'd6, 8'hc3, 1'b1, 1'b1, 7'd1), 1'b1,
            mk_res(1'b1, 8'hc3, 1'b1, 1'b1, 7'd1));
    add_row(mk_item(1'b1, 64'd8, 8'h0f, 1'b0, 1'b0, 7'd2), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd9, 8'hf0, 1'b0, 1'b0, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd7, 8'h5e, 1'b1, 1'b0, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b0, 64'haaaa_aaaa_aaaa_aaaa, 8'h00, 1'b0, 1'b0, 7'd0), 1'b0, '0);
    add_row(mk_item(1'b1, 64'd9, 8'he7, 1'b1, 1'b0, 7'd0), 1'b1,
            mk_res(1'b0, 8'h00, 1'b1, 1'b0, 7'd1));
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    // random segments
    sent       = 0;
    fill_due   = 1'b0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (sent < 330 || fill_due) begin
      seg_q.delete();
      tx_calm = ($urandom_range(0, 4) == 0);
      sp      = $urandom_range(0, 1) ? SW'(64) : SW'($urandom_range(0, 64));
      kind    = fill_due ? 10 : $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          add_run(exp_next + IW'($urandom_range(0, 3)), $urandom_range(1, 8), sp,
                  $urandom_range(0, 9) == 0, 1'($urandom));
        end
        3, 4: begin
          // bytes ahead of a hole, the hole byte follows as its own segment
          add_run(exp_next + 64'd1,
                  ($urandom_range(0, 19) == 0) ? 63 : $urandom_range(1, 12),
                  SW'(64), 1'b0, 1'($urandom));
          fill_due = 1'b1;
        end
        5: begin
          add_run((exp_next >= 64'd4) ? exp_next - 64'd4 : '0, $urandom_range(2, 10), sp,
                  1'b0, 1'b0);
        end
        6: begin
          seg_q.push_back(mk_item(1'b0,
                                  $urandom_range(0, 1) ? exp_next + IW'($urandom_range(0, 3))
                                                       : {$urandom, $urandom},
                                  DW'($urandom), 1'b1, $urandom_range(0, 2) == 0, sp));
        end
        7: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++) begin
            seg_q.push_back(mk_item(1'($urandom),
                                    $urandom_range(0, 1) ? {$urandom, $urandom}
                                                         : exp_next + IW'($urandom_range(0, 70)),
                                    DW'($urandom), i == len - 1, 1'($urandom),
                                    ($urandom_range(0, 9) == 0) ? SW'($urandom_range(65, 127))
                                                                : SW'($urandom_range(0, 64))));
          end
        end
        8: begin
          add_run(exp_next, $urandom_range(1, 8), SW'($urandom_range(0, 4)), 1'b0, 1'b0);
        end
        9: begin
          len = $urandom_range(0, 4);
          if (len == 0) begin
            seg_q.push_back(mk_item(1'b0, exp_next, DW'($urandom), 1'b1, 1'b1, sp));
          end else begin
            add_run(exp_next, len, sp, 1'b1, 1'b0);
          end
        end
        default: begin
          add_run(exp_next, 1, SW'(64), 1'b0, 1'b0);
          fill_due = 1'b0;
        end
      endcase
      foreach (seg_q[i]) begin
        send_item(seg_q[i], 1'b0, '0);
        sent++;
      end
      if (!hold_done && sent >= 100) begin
        hold_done = 1'b1;
        hold_req  = 1'b1;
      end
      if (!pause_done && sent >= 220) begin
        pause_done = 1'b1;
        seg_valid <= 1'b0;
        do @(posedge clk); while (drained_due.size() != 0);
      end
    end
    seg_valid <= 1'b0;

    wait_cnt = 0;
    while (drained_due.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (40) @(posedge clk);
    if (drained_due.size() != 0) begin
      report_mismatch("results never delivered", 64'(drained_due.size()), 64'd0);
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // output side: random stalls, one long hold-off, check of every transaction
  initial begin
    int         w;
    drain_res_t want;
    res_stall <= 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) rx_calm = ~rx_calm;
      if (hold_req) begin
        res_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        w = rx_calm ? 0 : $urandom_range(0, 12);
        if (w > 0) begin
          res_stall <= 1'b1;
          repeat (w) @(posedge clk);
        end
      end
      res_stall <= 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      if (drained_due.size() == 0) begin
        report_mismatch("result with nothing due",
                        64'({byte_valid, out_byte, last_of_run, stream_closed, pending_count}),
                        64'd0);
      end else begin
        want = drained_due.pop_front();
        if (byte_valid !== want.bv) begin
          report_mismatch("byte_valid", 64'(byte_valid), 64'(want.bv));
        end
        if (out_byte !== want.b) report_mismatch("out_byte", 64'(out_byte), 64'(want.b));
        if (last_of_run !== want.last) begin
          report_mismatch("last_of_run", 64'(last_of_run), 64'(want.last));
        end
        if (stream_closed !== want.closed) begin
          report_mismatch("stream_closed", 64'(stream_closed), 64'(want.closed));
        end
        if (pending_count !== want.pend) begin
          report_mismatch("pending_count", 64'(pending_count), 64'(want.pend));
        end
      end
    end
  end

endmodule

>>> sim.f
+incdir+sv
sv/tcpr_pkg.sv
sv/tcpr_ram.sv
sv/tcpr_ctrl.sv
sv/tcpr_dpath.sv
sv/tcp_byte_stream_reassembler_top.sv
sim/tb.sv
